// ===== src/rtpd_pkg.sv =====
// Shared widths, constants and register codes for the range-to-planar-depth pipeline.
package rtpd_pkg;

    localparam int COORD_BITS = 12;
    localparam int D_W        = 24;
    localparam int F_W        = 32;
    localparam int FRAC_SH    = 16;
    localparam int K_W        = D_W + F_W - FRAC_SH;
    localparam int L_W        = K_W + COORD_BITS - FRAC_SH;
    localparam int SQ_W       = 2 * D_W;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int MM_W       = 10;
    localparam int DEP_W      = 16;
    localparam int VIEW_W     = 8;
    localparam int NUM_W      = DEP_W + VIEW_W;
    localparam int GEOM_N     = 4;
    localparam int VIEW_N     = 2 + VIEW_W;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int IN_W       = D_W + 2 * COORD_BITS;
    localparam int OUT_W      = DEP_W + VIEW_W;

    localparam logic [MM_W-1:0]   MM_PER_M  = MM_W'(1000);
    localparam logic [DEP_W-1:0]  DEPTH_MAX = '1;
    localparam logic [VIEW_W-1:0] VIEW_MAX  = '1;

    localparam logic [1:0] REG_HALF_W = 2'd0;
    localparam logic [1:0] REG_HALF_H = 2'd1;
    localparam logic [1:0] REG_FOCAL  = 2'd2;
    localparam logic [1:0] REG_VRANGE = 2'd3;

    localparam logic [COORD_BITS-1:0] RST_HALF_W = COORD_BITS'(160);
    localparam logic [COORD_BITS-1:0] RST_HALF_H = COORD_BITS'(120);
    localparam logic [F_W-1:0]        RST_FOCAL  = F_W'(15036680);
    localparam logic [DEP_W-1:0]      RST_VRANGE = DEP_W'(2500);

endpackage

// ===== src/rtpd_geom.sv =====
// Lateral offsets and radicand: four register stages from pixel to d^2 - x^2 - y^2.
module rtpd_geom (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [rtpd_pkg::D_W-1:0]          i_range_q,
    input  logic [rtpd_pkg::COORD_BITS-1:0]   i_column,
    input  logic [rtpd_pkg::COORD_BITS-1:0]   i_row,
    input  logic [rtpd_pkg::COORD_BITS-1:0]   i_half_width,
    input  logic [rtpd_pkg::COORD_BITS-1:0]   i_half_height,
    input  logic [rtpd_pkg::F_W-1:0]          i_focal,
    output logic                              o_vld,
    output logic [rtpd_pkg::SQ_W-1:0]         o_rad
);
    localparam int DW = rtpd_pkg::D_W;
    localparam int FW = rtpd_pkg::F_W;
    localparam int CB = rtpd_pkg::COORD_BITS;
    localparam int KW = rtpd_pkg::K_W;
    localparam int LW = rtpd_pkg::L_W;
    localparam int SW = rtpd_pkg::SQ_W;
    localparam int SH = rtpd_pkg::FRAC_SH;

    logic [rtpd_pkg::GEOM_N-1:0] r_vld;

    logic [DW-1:0] r1_d, r2_d;
    logic [KW-1:0] r1_k;
    logic [CB-1:0] r1_ax, r1_ay;
    logic [LW-1:0] r2_xm, r2_ym;
    logic          r3_ok;
    logic [SW-1:0] r3_dd, r3_xx, r3_yy;
    logic [SW-1:0] r4_rad;

    logic [DW+FW-1:0] w_kprod;
    logic [KW+CB-1:0] w_xprod, w_yprod;
    logic [SW:0]      w_side;
    logic [CB-1:0]    w_ax, w_ay;

    assign w_kprod = {{FW{1'b0}}, i_range_q} * {{DW{1'b0}}, i_focal};
    assign w_ax = (i_column >= i_half_width) ? i_column - i_half_width
                                             : i_half_width - i_column;
    assign w_ay = (i_row >= i_half_height) ? i_row - i_half_height
                                           : i_half_height - i_row;
    assign w_xprod = {{CB{1'b0}}, r1_k} * {{KW{1'b0}}, r1_ax};
    assign w_yprod = {{CB{1'b0}}, r1_k} * {{KW{1'b0}}, r1_ay};
    assign w_side  = {1'b0, r3_xx} + {1'b0, r3_yy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rtpd_pkg::GEOM_N-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d   <= i_range_q;
            r1_k   <= w_kprod[DW+FW-1:SH];
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r2_d   <= r1_d;
            r2_xm  <= w_xprod[KW+CB-1:SH];
            r2_ym  <= w_yprod[KW+CB-1:SH];
            // lateral beyond the ray itself means no real depth
            r3_ok  <= (r2_xm <= LW'(r2_d)) && (r2_ym <= LW'(r2_d));
            r3_dd  <= {{DW{1'b0}}, r2_d} * {{DW{1'b0}}, r2_d};
            r3_xx  <= {{DW{1'b0}}, r2_xm[DW-1:0]} * {{DW{1'b0}}, r2_xm[DW-1:0]};
            r3_yy  <= {{DW{1'b0}}, r2_ym[DW-1:0]} * {{DW{1'b0}}, r2_ym[DW-1:0]};
            r4_rad <= (r3_ok && (w_side <= {1'b0, r3_dd})) ? r3_dd - w_side[SW-1:0] : '0;
        end
    end

    assign o_vld = r_vld[rtpd_pkg::GEOM_N-1];
    assign o_rad = r4_rad;

endmodule

// ===== src/rtpd_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
module rtpd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rtpd_pkg::SQ_W-1:0]     i_rad,
    output logic                          o_vld,
    output logic [rtpd_pkg::ROOT_W-1:0]   o_root
);
    localparam int N  = rtpd_pkg::ROOT_W;
    localparam int SW = rtpd_pkg::SQ_W;
    localparam int RW = rtpd_pkg::REM_W;

    logic [N:0]    w_vld;
    logic [SW-1:0] w_rad  [N+1];
    logic [RW-1:0] w_rem  [N+1];
    logic [N-1:0]  w_root [N+1];

    assign w_vld[0]  = i_vld;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic          r_vld;
        logic [SW-1:0] r_rad;
        logic [RW-1:0] r_rem;
        logic [N-1:0]  r_root;
        logic [RW+1:0] w_cur, w_trial;
        logic          w_ge;

        // bring down the next two radicand bits, try root*4+1
        assign w_cur   = {w_rem[g], w_rad[g][SW-1 -: 2]};
        assign w_trial = {2'b00, w_root[g], 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {w_rad[g][SW-3:0], 2'b00};
                r_rem  <= w_ge ? RW'(w_cur - w_trial) : RW'(w_cur);
                r_root <= {w_root[g][N-2:0], w_ge};
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_rad[g+1]  = r_rad;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
    end

    assign o_vld  = w_vld[N];
    assign o_root = w_root[N];

endmodule

// ===== src/rtpd_view.sv =====
// Millimetre scaling with saturation, then a pipelined divide for the view level.
module rtpd_view (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rtpd_pkg::ROOT_W-1:0]   i_root,
    input  logic [rtpd_pkg::DEP_W-1:0]    i_view_range,
    output logic                          o_vld,
    output logic [rtpd_pkg::DEP_W-1:0]    o_depth,
    output logic [rtpd_pkg::VIEW_W-1:0]   o_view
);
    localparam int RTW = rtpd_pkg::ROOT_W;
    localparam int MW  = rtpd_pkg::MM_W;
    localparam int PW  = RTW + MW;
    localparam int DPW = rtpd_pkg::DEP_W;
    localparam int VW  = rtpd_pkg::VIEW_W;
    localparam int NW  = rtpd_pkg::NUM_W;
    localparam int SH  = rtpd_pkg::FRAC_SH;

    logic          ra_vld, rb_vld;
    logic [PW-1:0] ra_prod;
    logic [DPW-1:0] rb_dep;
    logic [NW-1:0]  rb_num;
    logic           rb_zero;
    logic [PW-SH-1:0] w_mm;
    logic [DPW-1:0]   w_dep;

    assign w_mm  = ra_prod[PW-1:SH];
    assign w_dep = (w_mm > (PW-SH)'(rtpd_pkg::DEPTH_MAX)) ? rtpd_pkg::DEPTH_MAX : w_mm[DPW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
        end else if (i_en) begin
            ra_vld <= i_vld;
            rb_vld <= ra_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_prod <= {{MW{1'b0}}, i_root} * {{RTW{1'b0}}, rtpd_pkg::MM_PER_M};
            rb_dep  <= w_dep;
            // depth*255 as depth*256 - depth
            rb_num  <= {w_dep, {VW{1'b0}}} - NW'(w_dep);
            rb_zero <= (i_view_range == '0) || (w_dep > i_view_range);
        end
    end

    // restoring divide, quotient below 256 since depth <= range here
    logic [VW:0]   w_vld;
    logic [NW-1:0] w_rem  [VW+1];
    logic [VW-1:0] w_q    [VW+1];
    logic [DPW-1:0] w_d   [VW+1];
    logic [VW:0]   w_zero;

    assign w_vld[0]  = rb_vld;
    assign w_rem[0]  = rb_num;
    assign w_q[0]    = '0;
    assign w_d[0]    = rb_dep;
    assign w_zero[0] = rb_zero;

    for (genvar g = 0; g < VW; g++) begin : g_div
        localparam int B = VW - 1 - g;
        logic           r_vld;
        logic [NW-1:0]  r_rem;
        logic [VW-1:0]  r_q;
        logic [DPW-1:0] r_d;
        logic           r_zero;
        logic [NW-1:0]  w_trial;
        logic           w_ge;

        assign w_trial = NW'(i_view_range) << B;
        assign w_ge    = (w_rem[g] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_rem[g] - w_trial : w_rem[g];
                r_q    <= {w_q[g][VW-2:0], w_ge};
                r_d    <= w_d[g];
                r_zero <= w_zero[g];
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_rem[g+1]  = r_rem;
        assign w_q[g+1]    = r_q;
        assign w_d[g+1]    = r_d;
        assign w_zero[g+1] = r_zero;
    end

    assign o_vld   = w_vld[VW];
    assign o_depth = w_d[VW];
    assign o_view  = w_zero[VW] ? '0 : w_q[VW];

endmodule

// ===== src/range_to_planar_depth_pixel.sv =====
// Top level: range-image pixel to planar depth and view level, with APB registers.
//
// Input stream (s_axis): one request per range-image pixel, tdata holds
// range_q (Q8.16 m), column and row. Output stream (m_axis): one request per
// pixel, in order, with depth_mm and view_level.
// Throughput: one pixel per cycle sustained while the skid slot is empty; every
// stage is a register stage fed by one step of work (one multiply, one root bit,
// one quotient bit). From input handshake to o valid the path runs through 4
// geometry stages, 24 square-root stages (one per root bit), 2 scaling stages,
// 8 divide stages (one per view-level bit) and the output register.
// The whole pipe advances together while the skid slot is empty. When the
// receiver stalls, the output register holds; one more arriving result
// parks in the skid slot, s_axis_tready drops and the pipe freezes without
// losing or repeating a request. Empty pipe slots never fill the skid slot.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: half_width 160, half_height 120, focal_reciprocal
// 15036680, view_range_mm 2500. Registers sit at byte addresses 0, 4, 8, 12;
// write them only while the pipe is empty.
module range_to_planar_depth_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rtpd_pkg::DATA_W-1:0]   pwdata,
    output logic [rtpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // pixel stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rtpd_pkg::IN_W-1:0]     s_axis_tdata,  // range_q, column, row
    // depth stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rtpd_pkg::OUT_W-1:0]    m_axis_tdata   // depth_mm, view_level
);
    localparam int CB  = rtpd_pkg::COORD_BITS;
    localparam int DW  = rtpd_pkg::D_W;
    localparam int DPW = rtpd_pkg::DEP_W;
    localparam int VW  = rtpd_pkg::VIEW_W;

    // configuration registers
    logic [CB-1:0]           r_half_w, r_half_h;
    logic [rtpd_pkg::F_W-1:0] r_focal;
    logic [DPW-1:0]          r_vrange;
    logic                    w_wr;
    logic [1:0]              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= rtpd_pkg::RST_HALF_W;
            r_half_h <= rtpd_pkg::RST_HALF_H;
            r_focal  <= rtpd_pkg::RST_FOCAL;
            r_vrange <= rtpd_pkg::RST_VRANGE;
        end else if (w_wr) begin
            unique case (w_idx)
                rtpd_pkg::REG_HALF_W: r_half_w <= pwdata[CB-1:0];
                rtpd_pkg::REG_HALF_H: r_half_h <= pwdata[CB-1:0];
                rtpd_pkg::REG_FOCAL:  r_focal  <= pwdata;
                rtpd_pkg::REG_VRANGE: r_vrange <= pwdata[DPW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rtpd_pkg::REG_HALF_W: prdata = 32'(r_half_w);
            rtpd_pkg::REG_HALF_H: prdata = 32'(r_half_h);
            rtpd_pkg::REG_FOCAL:  prdata = r_focal;
            rtpd_pkg::REG_VRANGE: prdata = 32'(r_vrange);
            default:              prdata = '0;
        endcase
    end

    // pipe advance: hold everything while a result is parked in the skid slot
    logic r_skid_vld, r_out_vld;
    logic w_en;
    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    logic                          w_g_vld, w_s_vld, w_p_vld;
    logic [rtpd_pkg::SQ_W-1:0]     w_rad;
    logic [rtpd_pkg::ROOT_W-1:0]   w_root;
    logic [DPW-1:0]                w_p_dep;
    logic [VW-1:0]                 w_p_view;

    rtpd_geom u_geom (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_vld         (s_axis_tvalid),
        .i_range_q     (s_axis_tdata[DW-1:0]),
        .i_column      (s_axis_tdata[DW+CB-1:DW]),
        .i_row         (s_axis_tdata[DW+2*CB-1:DW+CB]),
        .i_half_width  (r_half_w),
        .i_half_height (r_half_h),
        .i_focal       (r_focal),
        .o_vld         (w_g_vld),
        .o_rad         (w_rad)
    );

    rtpd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_g_vld),
        .i_rad   (w_rad),
        .o_vld   (w_s_vld),
        .o_root  (w_root)
    );

    rtpd_view u_view (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (w_s_vld),
        .i_root       (w_root),
        .i_view_range (r_vrange),
        .o_vld        (w_p_vld),
        .o_depth      (w_p_dep),
        .o_view       (w_p_view)
    );

    // output register plus one skid slot
    logic [DPW-1:0] r_out_dep, r_skid_dep;
    logic [VW-1:0]  r_out_view, r_skid_view;
    logic           w_out_free;
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_vld <= w_p_vld;
        end else if (w_p_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_dep  <= r_skid_dep;
                r_out_view <= r_skid_view;
            end
        end else if (w_out_free) begin
            r_out_dep  <= w_p_dep;
            r_out_view <= w_p_view;
        end else begin
            r_skid_dep  <= w_p_dep;
            r_skid_view <= w_p_view;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_view, r_out_dep};

    // a parked result always sits behind a presented one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot full with output register empty");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> (r_out_vld && $stable(m_axis_tdata)))
        else $error("output changed while stalled");

    // no depth means no view intensity
    a_zero_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_dep == '0)) |-> (r_out_view == '0))
        else $error("view level set for zero depth");

endmodule

// ===== dv/tb_range_to_planar_depth_pixel.sv =====
// Testbench for range_to_planar_depth_pixel: random and corner pixels against a scoreboard.
`timescale 1ns / 1ps

class depth_scoreboard;
    logic [11:0] half_w;
    logic [11:0] half_h;
    logic [31:0] focal_rcp;
    logic [15:0] vrange;
    logic [23:0] exp_q[$];
    int          errors;
    int          checked;

    function new();
        half_w    = 12'd160;
        half_h    = 12'd120;
        focal_rcp = 32'd15036680;
        vrange    = 16'd2500;
        errors    = 0;
        checked   = 0;
    endfunction

    static function logic [63:0] root_of(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Compute depth_mm and view_level of one pixel.
    function logic [23:0] depth_of(logic [23:0] rq, logic [11:0] col, logic [11:0] row);
        logic [63:0] d, k, ax, ay, xm, ym, dd, side, dep, vw;
        d   = {40'd0, rq};
        k   = (d * {32'd0, focal_rcp}) >> 16;
        ax  = (col >= half_w) ? 64'(col - half_w) : 64'(half_w - col);
        ay  = (row >= half_h) ? 64'(row - half_h) : 64'(half_h - row);
        xm  = (k * ax) >> 16;
        ym  = (k * ay) >> 16;
        dep = 0;
        vw  = 0;
        if (xm <= d && ym <= d) begin
            dd   = d * d;
            side = xm * xm + ym * ym;
            if (side <= dd) begin
                dep = (root_of(dd - side) * 64'd1000) >> 16;
                if (dep > 64'd65535) dep = 64'd65535;
            end
        end
        if (vrange != 0 && dep <= {48'd0, vrange}) vw = (dep * 64'd255) / {48'd0, vrange};
        return {vw[7:0], dep[15:0]};
    endfunction

    function void note_pixel(logic [47:0] px);
        exp_q.insert(exp_q.size(), depth_of(px[23:0], px[35:24], px[47:36]));
    endfunction

    function void check_depth(logic [23:0] got);
        logic [23:0] e;
        if (exp_q.size() == 0) begin
            $error("unexpected depth request %h", got);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        checked++;
        if (got[15:0] !== e[15:0]) begin
            $error("depth_mm expected %0d actual %0d", e[15:0], got[15:0]);
            errors++;
        end
        if (got[23:16] !== e[23:16]) begin
            $error("view_level expected %0d actual %0d", e[23:16], got[23:16]);
            errors++;
        end
    endfunction
endclass

module tb_range_to_planar_depth_pixel;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [rtpd_pkg::ADDR_W-1:0] paddr = '0;
    logic [rtpd_pkg::DATA_W-1:0] pwdata = '0;
    logic [rtpd_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [rtpd_pkg::IN_W-1:0]   s_axis_tdata = '0;   // range_q, column, row
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [rtpd_pkg::OUT_W-1:0]  m_axis_tdata;        // depth_mm, view_level

    depth_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int sent;

    range_to_planar_depth_pixel dut (.*);

    always #5 i_clk = ~i_clk;

    // Check each result on the edge it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_depth(m_axis_tdata);
    end

    // Stall the receiver at the current rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Write one register: setup cycle, then access cycle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= rtpd_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rtpd_pkg::REG_HALF_W: sb.half_w = val[11:0];
            rtpd_pkg::REG_HALF_H: sb.half_h = val[11:0];
            rtpd_pkg::REG_FOCAL:  sb.focal_rcp = val;
            default:              sb.vrange = val[15:0];
        endcase
    endtask

    // Send one pixel request, idling first at the current rate.
    task automatic send_pixel(logic [23:0] rq, logic [11:0] col, logic [11:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col, rq};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pixel({row, col, rq});
        sent++;
    endtask

    task automatic finish_stream();
        s_axis_tvalid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // Mostly pixels near the optical centre with real-world ranges; some wild ones.
    task automatic random_pixels(int n);
        logic [23:0] rq;
        logic [11:0] col, row;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) != 0) begin
                rq  = 24'($urandom_range(24'h0C0000));
                col = 12'(sb.half_w + $urandom_range(400) - 200);
                row = 12'(sb.half_h + $urandom_range(300) - 150);
            end else begin
                rq  = 24'($urandom);
                col = 12'($urandom);
                row = 12'($urandom);
            end
            send_pixel(rq, col, row);
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 24;
        recv_idle_pct = 66;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes and special cases.
        send_pixel(24'd0, 12'd0, 12'd0);
        send_pixel(24'hFFFFFF, 12'd160, 12'd120);          // depth saturates
        send_pixel(24'h010000, 12'd160, 12'd120);          // 1 m straight ahead
        send_pixel(24'h028000, 12'd150, 12'd110);
        send_pixel(24'hFFFFFF, 12'hFFF, 12'hFFF);          // negative radicand
        send_pixel(24'h008000, 12'd0, 12'hFFF);
        send_pixel(24'h000001, 12'd161, 12'd119);
        send_pixel(24'h555555, 12'hAAA, 12'h555);
        send_pixel(24'hAAAAAA, 12'h555, 12'hAAA);
        finish_stream();

        write_reg(rtpd_pkg::REG_FOCAL, 32'd0);             // zero focal: depth is range
        write_reg(rtpd_pkg::REG_VRANGE, 32'd0);            // zero view range
        send_pixel(24'h020000, 12'hFFF, 12'd0);
        send_pixel(24'hFFFFFF, 12'd0, 12'hFFF);
        finish_stream();
        write_reg(rtpd_pkg::REG_HALF_W, 32'hFFFF_FFFF);
        write_reg(rtpd_pkg::REG_HALF_H, 32'd1);
        write_reg(rtpd_pkg::REG_FOCAL, 32'hFFFF_FFFF);
        write_reg(rtpd_pkg::REG_VRANGE, 32'd65535);
        send_pixel(24'h100000, 12'hFFF, 12'd1);
        send_pixel(24'h100000, 12'hFFE, 12'd0);
        send_pixel(24'hFFFFFF, 12'd0, 12'd1);
        finish_stream();
        write_reg(rtpd_pkg::REG_HALF_W, 32'd1);
        write_reg(rtpd_pkg::REG_HALF_H, 32'd2048);
        write_reg(rtpd_pkg::REG_VRANGE, 32'd1);
        send_pixel(24'h000100, 12'd1, 12'd2048);
        send_pixel(24'h000050, 12'd1, 12'd2048);
        finish_stream();

        // Random phases with varied settings and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 66; recv_idle_pct = 24; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            write_reg(rtpd_pkg::REG_HALF_W, 32'($urandom_range(2048, 1)));
            write_reg(rtpd_pkg::REG_HALF_H, 32'($urandom_range(2048, 1)));
            write_reg(rtpd_pkg::REG_FOCAL, (ph % 3 == 0) ? 32'd15036680 : $urandom);
            write_reg(rtpd_pkg::REG_VRANGE,
                      (ph == 5) ? 32'd65535 : 32'($urandom_range(6000, 1)));
            random_pixels(120);
            finish_stream();
        end

        $display("Covered %0d pixels (%0d results checked) over corner and random settings,",
                 sent, sb.checked);
        $display("with sender and receiver stalls in both mixes and at full rate.");
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("tb_range_to_planar_depth_pixel: PASS");
        end else begin
            $display("tb_range_to_planar_depth_pixel: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_range_to_planar_depth_pixel: FAIL");
        $finish;
    end
endmodule
